>>> rtl/scp_pkg.sv
`default_nettype none
package scp_pkg;

    // default geometry of the coordinate and fixed-point formats
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // result coordinate width (signed, fixed point)
    localparam int OUT_W = 32;

endpackage
`default_nettype wire

>>> rtl/scp_div_pipe.sv
`default_nettype none
// Restoring divider, one quotient bit per register stage.
// Requires n_in < d_in * 2^QW. Side data travels with each beat.
module scp_div_pipe #(
    parameter int NW = 69,
    parameter int QW = 34,
    parameter int DW = 35,
    parameter int SW = 1
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] n_in,
    input  wire logic [DW-1:0] d_in,
    input  wire logic [SW-1:0] side_in,
    output logic      [QW-1:0] q_out,
    output logic      [SW-1:0] side_out
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] lo_reg   [QW];
    logic [DW-1:0] d_reg    [QW];
    logic [SW-1:0] side_reg [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++) begin : g_stage
            logic [DW-1:0] rem_prev;
            logic [QW-1:0] lo_prev;
            logic [DW-1:0] d_prev;
            logic [SW-1:0] side_prev;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          take;
            logic [DW-1:0] rem_next;
            logic [QW-1:0] lo_next;

            if (i == 0) begin : g_first
                assign rem_prev  = n_in[NW-1:QW];
                assign lo_prev   = n_in[QW-1:0];
                assign d_prev    = d_in;
                assign side_prev = side_in;
            end else begin : g_rest
                assign rem_prev  = rem_reg[i-1];
                assign lo_prev   = lo_reg[i-1];
                assign d_prev    = d_reg[i-1];
                assign side_prev = side_reg[i-1];
            end

            // shift in next dividend bit, subtract when it fits
            always_comb begin
                trial    = {rem_prev, lo_prev[QW-1]};
                diff     = trial - {1'b0, d_prev};
                take     = (trial >= {1'b0, d_prev});
                rem_next = take ? diff[DW-1:0] : trial[DW-1:0];
                lo_next  = {lo_prev[QW-2:0], take};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i]  <= rem_next;
                    lo_reg[i]   <= lo_next;
                    d_reg[i]    <= d_prev;
                    side_reg[i] <= side_prev;
                end
            end
        end
    endgenerate

    assign q_out    = lo_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule
`default_nettype wire

>>> rtl/segment_crossing_point.sv
`default_nettype none
// Segment crossing point, fully pipelined.
// Stages: differences, products, cross products, crossing decision, partial products,
// rounded dividend, the quotient stages (one bit each) and the output register.
// Throughput: one segment pair per cycle; a stall on m_ready freezes all stages.
// Reset (aresetn low, synchronous) clears all stage valid bits; data is not reset.
module segment_crossing_point #(
    parameter int COORD_BITS = scp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = scp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_seg_a_start_x,
    input  wire logic signed [COORD_BITS-1:0] s_seg_a_start_y,
    input  wire logic signed [COORD_BITS-1:0] s_seg_a_end_x,
    input  wire logic signed [COORD_BITS-1:0] s_seg_a_end_y,
    input  wire logic signed [COORD_BITS-1:0] s_seg_b_start_x,
    input  wire logic signed [COORD_BITS-1:0] s_seg_b_start_y,
    input  wire logic signed [COORD_BITS-1:0] s_seg_b_end_x,
    input  wire logic signed [COORD_BITS-1:0] s_seg_b_end_y,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_crosses,
    output logic signed [scp_pkg::OUT_W-1:0]  m_cross_x,
    output logic signed [scp_pkg::OUT_W-1:0]  m_cross_y
);
    import scp_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DFW  = C + 1;            // coordinate difference
    localparam int PW   = 2 * DFW;          // product of two differences
    localparam int XW   = PW + 1;           // cross product
    localparam int AW   = 2 * C + 2;        // cross product magnitude
    localparam int MW   = C + 1;            // delta magnitude
    localparam int NLO  = (AW + 1) / 2;
    localparam int NHI  = AW - NLO;
    localparam int PRW  = MW + AW;          // delta * num
    localparam int NW   = PRW + F + 2;      // dividend
    localparam int QW   = C + F + 2;        // quotient
    localparam int DDW  = NW - QW;          // divisor, 2 * den
    localparam int VW   = C + F + 4;        // final sum
    localparam int SXW  = 2 + C;            // x side: hit, neg, base
    localparam int SYW  = 1 + C;            // y side: neg, base

    logic en;

    // pipeline advances whenever the output slot is free or being taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: differences
    logic                  v1_reg;
    logic signed [DFW-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [DFW-1:0] w0x_reg, w0y_reg, w1x_reg, w1y_reg, v1x_reg, v1y_reg;
    logic signed [C-1:0]   ax1_reg, ay1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dax_reg <= DFW'(s_seg_a_end_x) - DFW'(s_seg_a_start_x);
            day_reg <= DFW'(s_seg_a_end_y) - DFW'(s_seg_a_start_y);
            dbx_reg <= DFW'(s_seg_b_end_x) - DFW'(s_seg_b_start_x);
            dby_reg <= DFW'(s_seg_b_end_y) - DFW'(s_seg_b_start_y);
            w0x_reg <= DFW'(s_seg_a_start_x) - DFW'(s_seg_b_start_x);
            w0y_reg <= DFW'(s_seg_a_start_y) - DFW'(s_seg_b_start_y);
            w1x_reg <= DFW'(s_seg_a_end_x) - DFW'(s_seg_b_start_x);
            w1y_reg <= DFW'(s_seg_a_end_y) - DFW'(s_seg_b_start_y);
            v1x_reg <= DFW'(s_seg_b_end_x) - DFW'(s_seg_a_start_x);
            v1y_reg <= DFW'(s_seg_b_end_y) - DFW'(s_seg_a_start_y);
            ax1_reg <= s_seg_a_start_x;
            ay1_reg <= s_seg_a_start_y;
        end
    end

    // stage 2: products of the side tests and the denominator
    logic                 v2_reg;
    logic signed [PW-1:0] pa0a_reg, pa0b_reg, pa1a_reg, pa1b_reg;
    logic signed [PW-1:0] pb0a_reg, pb0b_reg, pb1a_reg, pb1b_reg;
    logic signed [PW-1:0] pda_reg, pdb_reg;
    logic signed [DFW-1:0] dax2_reg, day2_reg;
    logic signed [C-1:0]  ax2_reg, ay2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa0a_reg <= dbx_reg * w0y_reg;
            pa0b_reg <= dby_reg * w0x_reg;
            pa1a_reg <= dbx_reg * w1y_reg;
            pa1b_reg <= dby_reg * w1x_reg;
            pb0a_reg <= day_reg * w0x_reg;
            pb0b_reg <= dax_reg * w0y_reg;
            pb1a_reg <= dax_reg * v1y_reg;
            pb1b_reg <= day_reg * v1x_reg;
            pda_reg  <= dax_reg * dby_reg;
            pdb_reg  <= day_reg * dbx_reg;
            dax2_reg <= dax_reg;
            day2_reg <= day_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
        end
    end

    // stage 3: cross products (num equals the first side test of A)
    logic                  v3_reg;
    logic signed [XW-1:0]  ca0_reg, ca1_reg, cb0_reg, cb1_reg, den3_reg;
    logic signed [DFW-1:0] dax3_reg, day3_reg;
    logic signed [C-1:0]   ax3_reg, ay3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ca0_reg  <= XW'(pa0a_reg) - XW'(pa0b_reg);
            ca1_reg  <= XW'(pa1a_reg) - XW'(pa1b_reg);
            cb0_reg  <= XW'(pb0a_reg) - XW'(pb0b_reg);
            cb1_reg  <= XW'(pb1a_reg) - XW'(pb1b_reg);
            den3_reg <= XW'(pda_reg) - XW'(pdb_reg);
            dax3_reg <= dax2_reg;
            day3_reg <= day2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
        end
    end

    // stage 4: crossing decision and magnitudes
    logic          hit_next;
    logic [XW-1:0] den_abs_w, num_abs_w;
    logic [DFW-1:0] magx_w, magy_w;

    always_comb begin
        hit_next = (((ca0_reg < 0) && (ca1_reg > 0)) || ((ca0_reg > 0) && (ca1_reg < 0)))
                && (((cb0_reg < 0) && (cb1_reg > 0)) || ((cb0_reg > 0) && (cb1_reg < 0)))
                && (den3_reg != 0);
        den_abs_w = den3_reg[XW-1] ? XW'(-den3_reg) : XW'(den3_reg);
        num_abs_w = ca0_reg[XW-1]  ? XW'(-ca0_reg)  : XW'(ca0_reg);
        magx_w    = dax3_reg[DFW-1] ? DFW'(-dax3_reg) : DFW'(dax3_reg);
        magy_w    = day3_reg[DFW-1] ? DFW'(-day3_reg) : DFW'(day3_reg);
    end

    logic          v4_reg;
    logic          hit4_reg, negx4_reg, negy4_reg;
    logic [AW-1:0] den4_reg, num4_reg;
    logic [MW-1:0] magx4_reg, magy4_reg;
    logic signed [C-1:0] ax4_reg, ay4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit4_reg  <= hit_next;
            negx4_reg <= dax3_reg[DFW-1];
            negy4_reg <= day3_reg[DFW-1];
            den4_reg  <= den_abs_w[AW-1:0];
            num4_reg  <= num_abs_w[AW-1:0];
            magx4_reg <= magx_w;
            magy4_reg <= magy_w;
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
        end
    end

    // stage 5: delta * num as two partial products
    logic                v5_reg;
    logic                hit5_reg, negx5_reg, negy5_reg;
    logic [MW+NLO-1:0]   pxl_reg, pyl_reg;
    logic [MW+NHI-1:0]   pxh_reg, pyh_reg;
    logic [AW-1:0]       den5_reg;
    logic signed [C-1:0] ax5_reg, ay5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pxl_reg   <= (MW+NLO)'(magx4_reg) * (MW+NLO)'(num4_reg[NLO-1:0]);
            pxh_reg   <= (MW+NHI)'(magx4_reg) * (MW+NHI)'(num4_reg[AW-1:NLO]);
            pyl_reg   <= (MW+NLO)'(magy4_reg) * (MW+NLO)'(num4_reg[NLO-1:0]);
            pyh_reg   <= (MW+NHI)'(magy4_reg) * (MW+NHI)'(num4_reg[AW-1:NLO]);
            hit5_reg  <= hit4_reg;
            negx5_reg <= negx4_reg;
            negy5_reg <= negy4_reg;
            den5_reg  <= den4_reg;
            ax5_reg   <= ax4_reg;
            ay5_reg   <= ay4_reg;
        end
    end

    // stage 6: rounded dividend and divisor
    logic                v6_reg;
    logic [NW-1:0]       nx6_reg, ny6_reg;
    logic [DDW-1:0]      d6_reg;
    logic                hit6_reg, negx6_reg, negy6_reg;
    logic signed [C-1:0] ax6_reg, ay6_reg;
    logic [PRW-1:0]      px_w, py_w;

    always_comb begin
        px_w = PRW'(pxl_reg) + (PRW'(pxh_reg) << NLO);
        py_w = PRW'(pyl_reg) + (PRW'(pyh_reg) << NLO);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx6_reg   <= (NW'(px_w) << (F + 1)) + NW'(den5_reg);
            ny6_reg   <= (NW'(py_w) << (F + 1)) + NW'(den5_reg);
            d6_reg    <= {den5_reg, 1'b0};
            hit6_reg  <= hit5_reg;
            negx6_reg <= negx5_reg;
            negy6_reg <= negy5_reg;
            ax6_reg   <= ax5_reg;
            ay6_reg   <= ay5_reg;
        end
    end

    // quotient stages
    logic [QW-1:0]  qx_w, qy_w;
    logic [SXW-1:0] sidex_w;
    logic [SYW-1:0] sidey_w;
    logic [QW-1:0]  vdiv_reg;

    scp_div_pipe #(.NW(NW), .QW(QW), .DW(DDW), .SW(SXW)) u_div_x (
        .aclk     (aclk),
        .en       (en),
        .n_in     (nx6_reg),
        .d_in     (d6_reg),
        .side_in  ({hit6_reg, negx6_reg, ax6_reg}),
        .q_out    (qx_w),
        .side_out (sidex_w)
    );

    scp_div_pipe #(.NW(NW), .QW(QW), .DW(DDW), .SW(SYW)) u_div_y (
        .aclk     (aclk),
        .en       (en),
        .n_in     (ny6_reg),
        .d_in     (d6_reg),
        .side_in  ({negy6_reg, ay6_reg}),
        .q_out    (qy_w),
        .side_out (sidey_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vdiv_reg <= '0;
        end else if (en) begin
            vdiv_reg <= {vdiv_reg[QW-2:0], v6_reg};
        end
    end

    // final: base plus or minus the offset, saturate, zero when no hit
    logic signed [VW-1:0]    sx_w, sy_w;
    logic signed [OUT_W-1:0] ox_w, oy_w;
    logic                    hit_w;

    always_comb begin
        hit_w = sidex_w[SXW-1];
        sx_w  = VW'(signed'(sidex_w[C-1:0])) <<< F;
        sy_w  = VW'(signed'(sidey_w[C-1:0])) <<< F;
        sx_w  = sidex_w[C] ? sx_w - VW'(qx_w) : sx_w + VW'(qx_w);
        sy_w  = sidey_w[C] ? sy_w - VW'(qy_w) : sy_w + VW'(qy_w);
        if (sx_w > VW'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) begin
            ox_w = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (sx_w < VW'(signed'({1'b1, {(OUT_W-1){1'b0}}}))) begin
            ox_w = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            ox_w = sx_w[OUT_W-1:0];
        end
        if (sy_w > VW'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) begin
            oy_w = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (sy_w < VW'(signed'({1'b1, {(OUT_W-1){1'b0}}}))) begin
            oy_w = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            oy_w = sy_w[OUT_W-1:0];
        end
        if (!hit_w) begin
            ox_w = '0;
            oy_w = '0;
        end
    end

    logic                    mv_reg, mc_reg;
    logic signed [OUT_W-1:0] mx_reg, my_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (en) begin
            mv_reg <= vdiv_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mc_reg <= hit_w;
            mx_reg <= ox_w;
            my_reg <= oy_w;
        end
    end

    assign m_valid   = mv_reg;
    assign m_crosses = mc_reg;
    assign m_cross_x = mx_reg;
    assign m_cross_y = my_reg;

`ifndef SYNTHESIS
    a_nohit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_crosses) |-> (m_cross_x == 0 && m_cross_y == 0))
        else $error("non-crossing beat carries a nonzero point");

    a_hit_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && hit4_reg) |-> (den4_reg != 0 && num4_reg < den4_reg))
        else $error("crossing with parameter outside the open unit interval");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en) |=> ($stable(vdiv_reg) && $stable(v6_reg)))
        else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire

>>> tb/segment_crossing_point_checker.sv
`default_nettype none
// Watches both channels of the crossing-point block, predicts each result
// from the accepted segment pair and compares it with what comes out.
module segment_crossing_point_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    input  wire logic                               s_ready,
    input  wire logic signed [scp_pkg::COORD_BITS_DEF-1:0] s_seg_a_start_x,
    input  wire logic signed [scp_pkg::COORD_BITS_DEF-1:0] s_seg_a_start_y,
    input  wire logic signed [scp_pkg::COORD_BITS_DEF-1:0] s_seg_a_end_x,
    input  wire logic signed [scp_pkg::COORD_BITS_DEF-1:0] s_seg_a_end_y,
    input  wire logic signed [scp_pkg::COORD_BITS_DEF-1:0] s_seg_b_start_x,
    input  wire logic signed [scp_pkg::COORD_BITS_DEF-1:0] s_seg_b_start_y,
    input  wire logic signed [scp_pkg::COORD_BITS_DEF-1:0] s_seg_b_end_x,
    input  wire logic signed [scp_pkg::COORD_BITS_DEF-1:0] s_seg_b_end_y,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire logic                               m_crosses,
    input  wire logic signed [scp_pkg::OUT_W-1:0]   m_cross_x,
    input  wire logic signed [scp_pkg::OUT_W-1:0]   m_cross_y,
    output int                                      fail_count,
    output int                                      waiting,
    output int                                      hit_count
);
    localparam int FB = scp_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic                             crosses;
        logic signed [scp_pkg::OUT_W-1:0] x;
        logic signed [scp_pkg::OUT_W-1:0] y;
    } crossing_t;

    crossing_t crossing_q[$];

    assign waiting = crossing_q.size();

    function automatic longint side_of(longint ux, longint uy, longint vx, longint vy);
        return ux * vy - uy * vx;
    endfunction

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // base * 2^FB + round(delta * num / den * 2^FB), ties away from zero, saturated
    function automatic logic signed [31:0] fixed_coord(longint base, longint delta,
                                                       longint num, longint den);
        logic [127:0] mag;
        logic [127:0] prod;
        logic [127:0] quo;
        longint       v;
        mag  = (delta < 0) ? 128'(-delta) : 128'(delta);
        prod = ((mag * 128'(num)) << (FB + 1)) + 128'(den);
        quo  = prod / (128'(den) << 1);
        v    = base * (longint'(1) << FB);
        v    = (delta < 0) ? v - longint'(quo) : v + longint'(quo);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic crossing_t crossing_of(longint ax0, longint ay0, longint ax1,
                                              longint ay1, longint bx0, longint by0,
                                              longint bx1, longint by1);
        crossing_t r;
        longint dax, day, dbx, dby, den, num;
        int sa0, sa1, sb0, sb1;
        dax = ax1 - ax0;
        day = ay1 - ay0;
        dbx = bx1 - bx0;
        dby = by1 - by0;
        sa0 = sign_of(side_of(dbx, dby, ax0 - bx0, ay0 - by0));
        sa1 = sign_of(side_of(dbx, dby, ax1 - bx0, ay1 - by0));
        sb0 = sign_of(side_of(dax, day, bx0 - ax0, by0 - ay0));
        sb1 = sign_of(side_of(dax, day, bx1 - ax0, by1 - ay0));
        den = side_of(dax, day, dbx, dby);
        num = side_of(bx0 - ax0, by0 - ay0, dbx, dby);
        r = '0;
        // strict crossing only: touching, collinear, parallel all give zero
        if (sa0 * sa1 >= 0 || sb0 * sb1 >= 0 || den == 0) return r;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num < 0) num = -num;
        r.crosses = 1'b1;
        r.x = fixed_coord(ax0, dax, num, den);
        r.y = fixed_coord(ay0, day, num, den);
        return r;
    endfunction

    initial begin
        fail_count = 0;
        hit_count  = 0;
    end

    // compare result beats first, then queue the prediction for an input beat
    always @(posedge aclk) begin
        crossing_t e;
        if (aresetn && m_valid && m_ready) begin
            if (crossing_q.size() == 0) begin
                $error("result beat with no pair outstanding");
                fail_count++;
            end else begin
                e = crossing_q.pop_front();
                if (e.crosses) hit_count++;
                if (m_crosses !== e.crosses) begin
                    $error("crosses: expected %0d, got %0d", e.crosses, m_crosses);
                    fail_count++;
                end
                if (m_cross_x !== e.x) begin
                    $error("cross_x: expected %0d, got %0d", e.x, m_cross_x);
                    fail_count++;
                end
                if (m_cross_y !== e.y) begin
                    $error("cross_y: expected %0d, got %0d", e.y, m_cross_y);
                    fail_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready)
            crossing_q.insert(crossing_q.size(),
                              crossing_of(s_seg_a_start_x, s_seg_a_start_y,
                                          s_seg_a_end_x, s_seg_a_end_y,
                                          s_seg_b_start_x, s_seg_b_start_y,
                                          s_seg_b_end_x, s_seg_b_end_y));
    end

    final begin
        if (crossing_q.size() != 0)
            $error("%0d results never arrived", crossing_q.size());
    end
endmodule
`default_nettype wire

>>> tb/segment_crossing_point_test.sv
`default_nettype none
module segment_crossing_point_test;
    localparam int CW       = scp_pkg::COORD_BITS_DEF;
    localparam int LATENCY  = 9 + scp_pkg::COORD_BITS_DEF + scp_pkg::FRAC_BITS_DEF;
    localparam int HOLD_LEN = 400;
    localparam int WD_LIMIT = 4000;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [CW-1:0]    pt [8];
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_crosses;
    logic signed [scp_pkg::OUT_W-1:0] m_cross_x, m_cross_y;
    int                      fail_count, waiting, hit_count;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    int                      hold_req = 0;
    int                      hold_done = 0;
    int                      hold_left = 0;
    int                      idle_count = 0;
    int                      pairs_sent = 0;

    initial for (int i = 0; i < 8; i++) pt[i] = '0;

    always #4 aclk = ~aclk;

    segment_crossing_point dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_seg_a_start_x(pt[0]), .s_seg_a_start_y(pt[1]),
        .s_seg_a_end_x(pt[2]), .s_seg_a_end_y(pt[3]),
        .s_seg_b_start_x(pt[4]), .s_seg_b_start_y(pt[5]),
        .s_seg_b_end_x(pt[6]), .s_seg_b_end_y(pt[7]),
        .m_valid(m_valid), .m_ready(m_ready), .m_crosses(m_crosses),
        .m_cross_x(m_cross_x), .m_cross_y(m_cross_y)
    );

    segment_crossing_point_checker chk (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_seg_a_start_x(pt[0]), .s_seg_a_start_y(pt[1]),
        .s_seg_a_end_x(pt[2]), .s_seg_a_end_y(pt[3]),
        .s_seg_b_start_x(pt[4]), .s_seg_b_start_y(pt[5]),
        .s_seg_b_end_x(pt[6]), .s_seg_b_end_y(pt[7]),
        .m_valid(m_valid), .m_ready(m_ready), .m_crosses(m_crosses),
        .m_cross_x(m_cross_x), .m_cross_y(m_cross_y),
        .fail_count(fail_count), .waiting(waiting), .hit_count(hit_count)
    );

    // receiver: long hold-off on request, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WD_LIMIT) begin
            $display("segment_crossing_point_test failed");
            $finish;
        end
    end

    // one pair beat, with random idle cycles ahead of it
    task automatic send_pair(input int c0, c1, c2, c3, c4, c5, c6, c7);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        pt[0] <= CW'(c0); pt[1] <= CW'(c1); pt[2] <= CW'(c2); pt[3] <= CW'(c3);
        pt[4] <= CW'(c4); pt[5] <= CW'(c5); pt[6] <= CW'(c6); pt[7] <= CW'(c7);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pairs_sent++;
    endtask

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // mostly pairs built around a shared center so they cross, plus noise
    task automatic send_random_pair();
        int kind, cx, cy, px, py, qx, qy;
        kind = $urandom_range(99);
        if (kind < 60) begin
            cx = rnd(-16000, 16000); cy = rnd(-16000, 16000);
            px = rnd(-16000, 16000); py = rnd(-16000, 16000);
            qx = rnd(-16000, 16000); qy = rnd(-16000, 16000);
            send_pair(cx + px, cy + py, cx - px + rnd(-3, 3), cy - py + rnd(-3, 3),
                      cx + qx, cy + qy, cx - qx + rnd(-3, 3), cy - qy + rnd(-3, 3));
        end else if (kind < 80) begin
            send_pair($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        end else begin
            // tiny grid: touching, collinear and parallel cases show up often
            send_pair(rnd(-2, 2), rnd(-2, 2), rnd(-2, 2), rnd(-2, 2),
                      rnd(-2, 2), rnd(-2, 2), rnd(-2, 2), rnd(-2, 2));
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes and each degenerate case
        send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
        send_pair(0, -32768, 0, 32767, -32768, 0, 32767, 0);
        send_pair(5, -10, 5, 10, -7, 3, 9, 3);
        send_pair(-32768, -32768, 32767, -32767, 0, -32768, 1, 32767);
        send_pair(0, 0, 10, 10, 10, 0, 0, 10);
        send_pair(0, 0, 3, 1, 1, 0, 0, 1);
        send_pair(0, 0, 10, 0, 5, 0, 5, 10);
        send_pair(0, 0, 10, 0, 10, -5, 10, 5);
        send_pair(0, 0, 10, 0, 2, 0, 8, 0);
        send_pair(0, 0, 10, 0, 0, 1, 10, 1);
        send_pair(3, 3, 3, 3, 0, 0, 6, 6);
        send_pair(0, 0, 6, 6, 3, 3, 3, 3);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
        send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
        send_pair(0, 0, 1, 2, 1, 0, 0, 1);
        send_pair(0, 0, 3, 0, 1, -1, 2, 1);

        // phases of idling on each side
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 87 : ((ph == 3) ? 11 : 0);
            recv_stall_pct = (ph == 2) ? 87 : ((ph == 3) ? 11 : 0);
            if (ph == 0) hold_req++;
            for (int i = 0; i < 370; i++) begin
                send_random_pair();
                if (ph == 3 && i == 180) wait_drained();
            end
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("%0d segment pairs checked, %0d of them crossing, under four idle mixes",
                 pairs_sent, hit_count);
        $display("including a long output hold-off and a full drain mid-run");
        if (fail_count == 0)
            $display("segment_crossing_point_test passed");
        else
            $display("segment_crossing_point_test failed");
        $finish;
    end
endmodule
`default_nettype wire
